### hdl/tmocf_pkg.sv
package tmocf_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned TILE_W     = 7;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PROD_W     = COORD_W + TILE_W;
    localparam int unsigned TILE_NUM_W = 2 * TILE_W;
    localparam int unsigned STEP_W     = $clog2(TILE_W);
    localparam int unsigned MASK_IDX_W = $clog2(MASK_W);

    // Tiles at or above either limit are never filtered.
    localparam int unsigned MASK_BITS      = 32;
    localparam int unsigned TILE_LIMIT     = 64;
    localparam int unsigned HEAT_ALPHA_MAX = 56;
    localparam int unsigned HEAT_RING      = 1;
    localparam int unsigned MIN_WALL       = 2;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_WIDTH_PX     = 3'd0;
    localparam cfg_index_t REG_HEIGHT_PX    = 3'd1;
    localparam cfg_index_t REG_TILE_ROWS    = 3'd2;
    localparam cfg_index_t REG_TILE_COLUMNS = 3'd3;
    localparam cfg_index_t REG_ENABLE_MASK  = 3'd4;

    localparam logic [COORD_W-1:0] RST_WIDTH_PX     = 16'd1920;
    localparam logic [COORD_W-1:0] RST_HEIGHT_PX    = 16'd1080;
    localparam logic [TILE_W-1:0]  RST_TILE_ROWS    = 7'd1;
    localparam logic [TILE_W-1:0]  RST_TILE_COLUMNS = 7'd1;
    localparam logic [MASK_W-1:0]  RST_ENABLE_MASK  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [COORD_W-1:0] width_px;
        logic [COORD_W-1:0] height_px;
        logic [TILE_W-1:0]  tile_rows;
        logic [TILE_W-1:0]  tile_columns;
        logic [MASK_W-1:0]  enable_mask;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               heat;
        logic               last;
    } queue_entry_t;

endpackage

### hdl/tmocf_front.sv
module tmocf_front
(
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // center_x[15:0], center_y[31:16], has_fill[32], ring_width[40:33],
    // fill_alpha[48:41], zero pad[55:49]
    input  logic [tmocf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    input  tmocf_pkg::cfg_t                    cfg,
    input  logic                               queue_full,
    output logic                               push,
    output tmocf_pkg::queue_entry_t            entry
);

    logic [tmocf_pkg::COORD_W-1:0] center_x;
    logic [tmocf_pkg::COORD_W-1:0] center_y;
    logic                          has_fill;
    logic [tmocf_pkg::BYTE_W-1:0]  ring_width;
    logic [tmocf_pkg::BYTE_W-1:0]  fill_alpha;
    logic                          geom_ok;
    logic                          heat_mark;

    assign center_x   = s_tdata[15:0];
    assign center_y   = s_tdata[31:16];
    assign has_fill   = s_tdata[32];
    assign ring_width = s_tdata[40:33];
    assign fill_alpha = s_tdata[48:41];

    // Bad geometry disables filtering altogether.
    assign geom_ok = (cfg.width_px >= tmocf_pkg::COORD_W'(tmocf_pkg::MIN_WALL))
                  && (cfg.height_px >= tmocf_pkg::COORD_W'(tmocf_pkg::MIN_WALL))
                  && (cfg.tile_rows != '0)
                  && (cfg.tile_columns != '0);

    assign heat_mark = geom_ok && has_fill
                    && (ring_width == tmocf_pkg::BYTE_W'(tmocf_pkg::HEAT_RING))
                    && (fill_alpha <= tmocf_pkg::BYTE_W'(tmocf_pkg::HEAT_ALPHA_MAX));

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        entry.center_x = center_x;
        entry.center_y = center_y;
        entry.heat     = heat_mark;
        entry.last     = s_tlast;
    end

endmodule

### hdl/tmocf_queue.sv
module tmocf_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tmocf_pkg::queue_entry_t push_entry,
    input  logic                    pop,
    output tmocf_pkg::queue_entry_t head,
    output logic                    full,
    output logic                    empty
);

    localparam int unsigned PTR_W = (tmocf_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(tmocf_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(tmocf_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tmocf_pkg::QUEUE_DEPTH - 1);

    tmocf_pkg::queue_entry_t mem [tmocf_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(tmocf_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/tmocf_div.sv
// Restoring divider for a quotient known to fit in TILE_W bits.
module tmocf_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tmocf_pkg::PROD_W-1:0]   dividend,
    input  logic [tmocf_pkg::COORD_W-1:0]  divisor,
    output logic [tmocf_pkg::TILE_W-1:0]   quotient,
    output logic                           done
);

    logic [tmocf_pkg::PROD_W-1:0] rem_reg;
    logic [tmocf_pkg::TILE_W-1:0] quo_reg;
    logic [tmocf_pkg::STEP_W-1:0] step_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [tmocf_pkg::PROD_W-1:0] trial;

    assign trial    = tmocf_pkg::PROD_W'(divisor) << step_reg;
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= dividend;
            quo_reg  <= '0;
            step_reg <= tmocf_pkg::STEP_W'(tmocf_pkg::TILE_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg           <= rem_reg - trial;
                quo_reg[step_reg] <= 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

### hdl/tmocf_back.sv
module tmocf_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmocf_pkg::cfg_t                   cfg,
    input  logic                              queue_empty,
    input  tmocf_pkg::queue_entry_t           head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tmocf_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TILE,
        ST_DECIDE
    } state_t;

    state_t                           state_reg;
    logic                             heat_reg;
    logic                             last_reg;
    logic                             x_clip_reg;
    logic                             y_clip_reg;
    logic [tmocf_pkg::TILE_W-1:0]     col_reg;
    logic [tmocf_pkg::TILE_W-1:0]     row_reg;
    logic [tmocf_pkg::TILE_NUM_W-1:0] tile_reg;
    logic [tmocf_pkg::COUNT_W-1:0]    wp_reg;
    logic [tmocf_pkg::COUNT_W-1:0]    removed_reg;
    logic                             out_valid_reg;
    logic [tmocf_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                             out_last_reg;

    logic                             div_start;
    logic [tmocf_pkg::PROD_W-1:0]     prod_x;
    logic [tmocf_pkg::PROD_W-1:0]     prod_y;
    logic [tmocf_pkg::TILE_W-1:0]     quo_x;
    logic [tmocf_pkg::TILE_W-1:0]     quo_y;
    logic                             done_x;
    logic                             done_y;
    logic [tmocf_pkg::TILE_W-1:0]     col_sel;
    logic [tmocf_pkg::TILE_W-1:0]     row_sel;
    logic [tmocf_pkg::TILE_NUM_W-1:0] tile_next;
    logic                             mask_keep;
    logic                             keep_now;
    logic                             out_free;
    logic                             post_word;
    logic [tmocf_pkg::COUNT_W-1:0]    slot_v;
    logic [tmocf_pkg::COUNT_W-1:0]    removed_v;

    assign pop       = (state_reg == ST_IDLE) && !queue_empty;
    assign div_start = pop && head.heat;
    assign prod_x    = tmocf_pkg::PROD_W'(head.center_x)
                     * tmocf_pkg::PROD_W'(cfg.tile_columns);
    assign prod_y    = tmocf_pkg::PROD_W'(head.center_y)
                     * tmocf_pkg::PROD_W'(cfg.tile_rows);

    tmocf_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_x),
        .divisor  (cfg.width_px),
        .quotient (quo_x),
        .done     (done_x)
    );

    tmocf_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_y),
        .divisor  (cfg.height_px),
        .quotient (quo_y),
        .done     (done_y)
    );

    // A coordinate past the wall edge lands on the last column or row.
    assign col_sel = x_clip_reg ? cfg.tile_columns - 1'b1 : quo_x;
    assign row_sel = y_clip_reg ? cfg.tile_rows - 1'b1 : quo_y;

    assign tile_next = tmocf_pkg::TILE_NUM_W'(row_reg)
                     * tmocf_pkg::TILE_NUM_W'(cfg.tile_columns)
                     + tmocf_pkg::TILE_NUM_W'(col_reg);

    always_comb
    begin
        if (tile_reg >= tmocf_pkg::TILE_NUM_W'(tmocf_pkg::MASK_BITS)
            || tile_reg >= tmocf_pkg::TILE_NUM_W'(tmocf_pkg::TILE_LIMIT))
        begin
            mask_keep = 1'b1;
        end
        else if (tile_reg < tmocf_pkg::TILE_NUM_W'(tmocf_pkg::MASK_W))
        begin
            mask_keep = cfg.enable_mask[tile_reg[tmocf_pkg::MASK_IDX_W-1:0]];
        end
        else
        begin
            mask_keep = 1'b0;
        end
    end

    assign keep_now  = !heat_reg || mask_keep;
    assign out_free  = !out_valid_reg || m_tready;
    assign post_word = (state_reg == ST_DECIDE) && out_free;
    assign slot_v    = keep_now ? wp_reg : '0;
    assign removed_v = (keep_now || removed_reg == '1) ? removed_reg
                                                       : removed_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            heat_reg      <= 1'b0;
            last_reg      <= 1'b0;
            x_clip_reg    <= 1'b0;
            y_clip_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            tile_reg      <= '0;
            wp_reg        <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (post_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        heat_reg   <= head.heat;
                        last_reg   <= head.last;
                        x_clip_reg <= (head.center_x >= cfg.width_px);
                        y_clip_reg <= (head.center_y >= cfg.height_px);
                        state_reg  <= head.heat ? ST_DIV : ST_DECIDE;
                    end
                end
                ST_DIV:
                begin
                    if (done_x && done_y)
                    begin
                        col_reg   <= col_sel;
                        row_reg   <= row_sel;
                        state_reg <= ST_TILE;
                    end
                end
                ST_TILE:
                begin
                    tile_reg  <= tile_next;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    // Hold until the output word is free.
                    if (out_free)
                    begin
                        out_data_reg  <= {7'd0, removed_v, slot_v, keep_now};
                        out_last_reg  <= last_reg;
                        removed_reg   <= removed_v;
                        if (last_reg)
                        begin
                            wp_reg <= '0;
                        end
                        else if (keep_now)
                        begin
                            wp_reg <= wp_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hdl/tile_mask_overlay_circle_filter_core.sv
// Overlay circle filter for a tiled video wall. Each input word is one circle;
// each circle gives exactly one output word carrying the keep flag, the
// compacted slot within its display list and the saturating count of removed
// circles. Input words land in a two-entry queue and are taken whenever it has
// room. A heat mark passes through the back end in order: load, seven
// restoring-division steps (column and row divided side by side), taking the
// quotients, forming the tile number and posting the result; any other circle
// goes from load straight to posting. The back end takes no new circle until
// it has posted the last one, so its pace is set mostly by the seven-step
// dividers, and it slows whenever a result word waits on m_tready. Write
// configuration only while no circle is in flight.
module tile_mask_overlay_circle_filter_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tmocf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmocf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // center_x[15:0], center_y[31:16], has_fill[32], ring_width[40:33],
    // fill_alpha[48:41], zero pad[55:49]
    input  logic [tmocf_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // keep[0], slot[16:1], removed_total[32:17], zero pad[39:33]
    output logic [tmocf_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    tmocf_pkg::cfg_t         cfg_reg;
    tmocf_pkg::queue_entry_t push_entry;
    tmocf_pkg::queue_entry_t head;
    logic                    push;
    logic                    pop;
    logic                    queue_full;
    logic                    queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_px     <= tmocf_pkg::RST_WIDTH_PX;
            cfg_reg.height_px    <= tmocf_pkg::RST_HEIGHT_PX;
            cfg_reg.tile_rows    <= tmocf_pkg::RST_TILE_ROWS;
            cfg_reg.tile_columns <= tmocf_pkg::RST_TILE_COLUMNS;
            cfg_reg.enable_mask  <= tmocf_pkg::RST_ENABLE_MASK;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tmocf_pkg::REG_WIDTH_PX:     cfg_reg.width_px     <= cfg_data[15:0];
                tmocf_pkg::REG_HEIGHT_PX:    cfg_reg.height_px    <= cfg_data[15:0];
                tmocf_pkg::REG_TILE_ROWS:    cfg_reg.tile_rows    <= cfg_data[6:0];
                tmocf_pkg::REG_TILE_COLUMNS: cfg_reg.tile_columns <= cfg_data[6:0];
                tmocf_pkg::REG_ENABLE_MASK:  cfg_reg.enable_mask  <= cfg_data;
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    tmocf_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    tmocf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    tmocf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### hdl/tmocf_checker.sv
module tmocf_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tmocf_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                              m_tlast
);

    // A stalled result word must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A removed circle has no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("removed circle carries a slot");

    // A removed circle was counted, so the total cannot be zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:17] != 16'd0)
        else $error("removed circle not counted");

    // Reset leaves no result word behind.
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tile_mask_overlay_circle_filter_core tmocf_checker u_checker (.*);

### dv/tb_tile_mask_overlay_circle_filter_core.sv
module tb_tile_mask_overlay_circle_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned SETTLE_CYCLES   = 20;
    localparam int unsigned PHASES          = 10;
    localparam int unsigned PHASE_CIRCLES   = 140;
    localparam int unsigned CLOSING_CIRCLES = 100;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned IN_FIELDS_W     = 49;

    typedef struct packed {
        logic [tmocf_pkg::COORD_W-1:0] center_x;
        logic [tmocf_pkg::COORD_W-1:0] center_y;
        logic                          has_fill;
        logic [tmocf_pkg::BYTE_W-1:0]  ring_width;
        logic [tmocf_pkg::BYTE_W-1:0]  fill_alpha;
        logic                          last_in_list;
    } circle_t;

    typedef struct packed {
        logic                          keep;
        logic [tmocf_pkg::COUNT_W-1:0] slot;
        logic [tmocf_pkg::COUNT_W-1:0] removed_total;
        logic                          list_end;
    } outcome_t;

    typedef struct packed {
        logic                             is_cfg;
        tmocf_pkg::cfg_index_t            idx;
        logic [tmocf_pkg::CFG_DATA_W-1:0] value;
        circle_t                          circ;
        logic                             typed;
        outcome_t                         want;
    } stim_row_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [tmocf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tmocf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [tmocf_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [tmocf_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tlast;

    tmocf_pkg::cfg_t               model_cfg;
    logic [tmocf_pkg::COUNT_W-1:0] next_slot;
    logic [tmocf_pkg::COUNT_W-1:0] removed_tally;
    outcome_t                      due_outcomes[$];
    stim_row_t                     script[$];
    int unsigned                   bad_outcomes = 0;
    int unsigned                   quiet_cycles = 0;
    int unsigned                   stall_left   = 0;
    bit                            idling       = 1'b1;

    tile_mask_overlay_circle_filter_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Decide keep/drop for one circle and advance slot and removal state.
    function automatic outcome_t judge_circle(input circle_t c);
        outcome_t    o;
        int unsigned x, y, w, h, rows, cols, col, row, tile;
        bit          kept;
        kept = 1'b1;
        x    = 32'(c.center_x);
        y    = 32'(c.center_y);
        w    = 32'(model_cfg.width_px);
        h    = 32'(model_cfg.height_px);
        rows = 32'(model_cfg.tile_rows);
        cols = 32'(model_cfg.tile_columns);
        if (w >= tmocf_pkg::MIN_WALL && h >= tmocf_pkg::MIN_WALL && rows != 0 && cols != 0
            && c.has_fill
            && c.ring_width == tmocf_pkg::BYTE_W'(tmocf_pkg::HEAT_RING)
            && c.fill_alpha <= tmocf_pkg::BYTE_W'(tmocf_pkg::HEAT_ALPHA_MAX))
        begin
            col = (x * cols) / w;
            row = (y * rows) / h;
            if (col >= cols)
                col = cols - 1;
            if (row >= rows)
                row = rows - 1;
            tile = row * cols + col;
            if (tile < tmocf_pkg::MASK_BITS && tile < tmocf_pkg::TILE_LIMIT)
                kept = model_cfg.enable_mask[tile];
        end
        o.keep     = kept;
        o.list_end = c.last_in_list;
        if (kept)
        begin
            o.slot    = next_slot;
            next_slot = next_slot + 1'b1;
        end
        else
        begin
            o.slot = '0;
            if (removed_tally != '1)
                removed_tally = removed_tally + 1'b1;
        end
        o.removed_total = removed_tally;
        if (c.last_in_list)
            next_slot = '0;
        return o;
    endfunction

    function automatic stim_row_t cfg_row(input tmocf_pkg::cfg_index_t idx,
                                          input logic [tmocf_pkg::CFG_DATA_W-1:0] value);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        return r;
    endfunction

    function automatic stim_row_t circle_row(input logic [15:0] x, input logic [15:0] y,
                                             input logic fill, input logic [7:0] ring,
                                             input logic [7:0] alpha, input logic last,
                                             input logic typed, input logic keep,
                                             input logic [15:0] slot,
                                             input logic [15:0] removed);
        stim_row_t r;
        r                    = '0;
        r.circ               = '{x, y, fill, ring, alpha, last};
        r.typed              = typed;
        r.want               = '{keep, slot, removed, last};
        return r;
    endfunction

    // Mostly heat marks on the wall so the tile lookup is reached; the rest is noise.
    function automatic circle_t random_circle();
        circle_t c;
        c.center_x     = tmocf_pkg::COORD_W'($urandom);
        c.center_y     = tmocf_pkg::COORD_W'($urandom);
        c.has_fill     = 1'($urandom);
        c.ring_width   = tmocf_pkg::BYTE_W'($urandom);
        c.fill_alpha   = tmocf_pkg::BYTE_W'($urandom);
        c.last_in_list = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 7)
        begin
            c.has_fill   = 1'b1;
            c.ring_width = tmocf_pkg::BYTE_W'(tmocf_pkg::HEAT_RING);
            if ($urandom_range(0, 3) == 0)
                c.fill_alpha = tmocf_pkg::BYTE_W'($urandom_range(
                                   tmocf_pkg::HEAT_ALPHA_MAX - 1,
                                   tmocf_pkg::HEAT_ALPHA_MAX + 2));
            else
                c.fill_alpha = tmocf_pkg::BYTE_W'($urandom_range(
                                   0, tmocf_pkg::HEAT_ALPHA_MAX));
            if ($urandom_range(0, 7) != 0 && model_cfg.width_px != 0
                && model_cfg.height_px != 0)
            begin
                c.center_x = tmocf_pkg::COORD_W'($urandom_range(
                                 0, 32'(model_cfg.width_px) - 1));
                c.center_y = tmocf_pkg::COORD_W'($urandom_range(
                                 0, 32'(model_cfg.height_px) - 1));
            end
        end
        return c;
    endfunction

    task automatic write_reg(input tmocf_pkg::cfg_index_t idx,
                             input logic [tmocf_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        unique case (idx)
            tmocf_pkg::REG_WIDTH_PX:
                model_cfg.width_px     = value[tmocf_pkg::COORD_W-1:0];
            tmocf_pkg::REG_HEIGHT_PX:
                model_cfg.height_px    = value[tmocf_pkg::COORD_W-1:0];
            tmocf_pkg::REG_TILE_ROWS:
                model_cfg.tile_rows    = value[tmocf_pkg::TILE_W-1:0];
            tmocf_pkg::REG_TILE_COLUMNS:
                model_cfg.tile_columns = value[tmocf_pkg::TILE_W-1:0];
            tmocf_pkg::REG_ENABLE_MASK:
                model_cfg.enable_mask  = value[tmocf_pkg::MASK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold the sender until every outstanding word has come back.
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (due_outcomes.size() != 0);
    endtask

    task automatic send_circle(input circle_t c, input logic typed, input outcome_t want);
        outcome_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tmocf_pkg::IN_DATA_W - IN_FIELDS_W){1'b0}}, c.fill_alpha,
                     c.ring_width, c.has_fill, c.center_y, c.center_x};
        s_tlast  <= c.last_in_list;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = judge_circle(c);
        due_outcomes.push_back(typed ? want : predicted);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_side
        outcome_t seen;
        outcome_t want;
        if (m_tvalid && m_tready)
        begin
            seen = {m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tlast};
            if (due_outcomes.size() == 0)
            begin
                if (bad_outcomes < REPORT_LIMIT)
                    $display("unexpected result word: keep %0d slot %0d removed %0d end %0d",
                             seen.keep, seen.slot, seen.removed_total, seen.list_end);
                bad_outcomes++;
            end
            else
            begin
                want = due_outcomes.pop_front();
                if (seen.keep !== want.keep || seen.slot !== want.slot
                    || seen.removed_total !== want.removed_total
                    || seen.list_end !== want.list_end)
                begin
                    if (bad_outcomes < REPORT_LIMIT)
                        $display({"mismatch: keep %0d/%0d slot %0d/%0d removed %0d/%0d ",
                                  "end %0d/%0d (expected/actual)"},
                                 want.keep, seen.keep, want.slot, seen.slot,
                                 want.removed_total, seen.removed_total,
                                 want.list_end, seen.list_end);
                    bad_outcomes++;
                end
            end
        end

        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end

        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        circle_t c;
        model_cfg.width_px     = tmocf_pkg::RST_WIDTH_PX;
        model_cfg.height_px    = tmocf_pkg::RST_HEIGHT_PX;
        model_cfg.tile_rows    = tmocf_pkg::RST_TILE_ROWS;
        model_cfg.tile_columns = tmocf_pkg::RST_TILE_COLUMNS;
        model_cfg.enable_mask  = tmocf_pkg::RST_ENABLE_MASK;
        next_slot              = '0;
        removed_tally          = '0;

        // Reset values: one tile, all enabled.
        script.push_back(circle_row(16'd0, 16'd0, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b1, 1'b1, 16'd0, 16'd0));
        script.push_back(circle_row(16'hFFFF, 16'hFFFF, 1'b0, 8'hFF, 8'hFF, 1'b1,
                                    1'b1, 1'b1, 16'd1, 16'd0));
        script.push_back(cfg_row(tmocf_pkg::REG_ENABLE_MASK, 32'h0));
        // Heat threshold edges and non-heat shapes.
        script.push_back(circle_row(16'hFFFF, 16'hFFFF, 1'b1, 8'd1, 8'd56, 1'b0,
                                    1'b1, 1'b0, 16'd0, 16'd1));
        script.push_back(circle_row(16'd100, 16'd100, 1'b1, 8'd1, 8'd57, 1'b0,
                                    1'b1, 1'b1, 16'd0, 16'd1));
        script.push_back(circle_row(16'd100, 16'd100, 1'b1, 8'd0, 8'd0, 1'b0,
                                    1'b1, 1'b1, 16'd1, 16'd1));
        script.push_back(circle_row(16'd100, 16'd100, 1'b1, 8'd2, 8'd0, 1'b0,
                                    1'b1, 1'b1, 16'd2, 16'd1));
        script.push_back(circle_row(16'd100, 16'd100, 1'b0, 8'd1, 8'd0, 1'b1,
                                    1'b1, 1'b1, 16'd3, 16'd1));
        script.push_back(circle_row(16'd0, 16'd0, 1'b1, 8'd1, 8'd0, 1'b1,
                                    1'b1, 1'b0, 16'd0, 16'd2));
        // Largest wall on a 64 by 64 tile grid; tiles beyond the mask are kept.
        script.push_back(cfg_row(tmocf_pkg::REG_WIDTH_PX, 32'hFFFF));
        script.push_back(cfg_row(tmocf_pkg::REG_HEIGHT_PX, 32'hFFFF));
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_ROWS, 32'd64));
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_COLUMNS, 32'd64));
        script.push_back(cfg_row(tmocf_pkg::REG_ENABLE_MASK, 32'hA5A5_5A5A));
        script.push_back(circle_row(16'd0, 16'd0, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b0, 1'b0, 16'd0, 16'd0));
        script.push_back(circle_row(16'h7FFF, 16'd0, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b0, 1'b0, 16'd0, 16'd0));
        script.push_back(circle_row(16'hFFFF, 16'd0, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b0, 1'b0, 16'd0, 16'd0));
        script.push_back(circle_row(16'd0, 16'hFFFF, 1'b1, 8'd1, 8'd0, 1'b1,
                                    1'b0, 1'b0, 16'd0, 16'd0));
        // Grid counts above 64.
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_ROWS, 32'd127));
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_COLUMNS, 32'd127));
        script.push_back(circle_row(16'hFFFF, 16'hFFFF, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b0, 1'b0, 16'd0, 16'd0));
        script.push_back(circle_row(16'd300, 16'd0, 1'b1, 8'd1, 8'd0, 1'b1,
                                    1'b0, 1'b0, 16'd0, 16'd0));
        // Invalid geometry keeps everything, even with the mask cleared.
        script.push_back(cfg_row(tmocf_pkg::REG_ENABLE_MASK, 32'h0));
        script.push_back(cfg_row(tmocf_pkg::REG_WIDTH_PX, 32'd1));
        script.push_back(circle_row(16'd0, 16'd0, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b1, 1'b1, 16'd0, 16'd4));
        script.push_back(cfg_row(tmocf_pkg::REG_WIDTH_PX, 32'd2));
        script.push_back(cfg_row(tmocf_pkg::REG_HEIGHT_PX, 32'd0));
        script.push_back(circle_row(16'd1, 16'd1, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b1, 1'b1, 16'd1, 16'd4));
        script.push_back(cfg_row(tmocf_pkg::REG_HEIGHT_PX, 32'd2));
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_ROWS, 32'd0));
        script.push_back(circle_row(16'd1, 16'd1, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b1, 1'b1, 16'd2, 16'd4));
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_ROWS, 32'd1));
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_COLUMNS, 32'd0));
        script.push_back(circle_row(16'd1, 16'd1, 1'b1, 8'd1, 8'd0, 1'b1,
                                    1'b1, 1'b1, 16'd3, 16'd4));
        // Smallest valid wall, mask clear: every heat mark goes.
        script.push_back(cfg_row(tmocf_pkg::REG_TILE_COLUMNS, 32'd1));
        script.push_back(circle_row(16'd1, 16'd1, 1'b1, 8'd1, 8'd0, 1'b0,
                                    1'b1, 1'b0, 16'd0, 16'd5));
        script.push_back(circle_row(16'hFFFF, 16'hFFFF, 1'b1, 8'd1, 8'd0, 1'b1,
                                    1'b1, 1'b0, 16'd0, 16'd6));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain_outcomes();
                write_reg(script[i].idx, script[i].value);
            end
            else
                send_circle(script[i].circ, script[i].typed, script[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_outcomes();
            case ($urandom_range(0, 5))
                0:       write_reg(tmocf_pkg::REG_WIDTH_PX, $urandom_range(0, 1));
                1:       write_reg(tmocf_pkg::REG_WIDTH_PX, tmocf_pkg::MIN_WALL);
                2:       write_reg(tmocf_pkg::REG_WIDTH_PX, 32'hFFFF);
                default: write_reg(tmocf_pkg::REG_WIDTH_PX,
                                   $urandom_range(tmocf_pkg::MIN_WALL, 4096));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(tmocf_pkg::REG_HEIGHT_PX, $urandom_range(0, 1));
                1:       write_reg(tmocf_pkg::REG_HEIGHT_PX, tmocf_pkg::MIN_WALL);
                2:       write_reg(tmocf_pkg::REG_HEIGHT_PX, 32'hFFFF);
                default: write_reg(tmocf_pkg::REG_HEIGHT_PX,
                                   $urandom_range(tmocf_pkg::MIN_WALL, 4096));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(tmocf_pkg::REG_TILE_ROWS, 32'd0);
                1:       write_reg(tmocf_pkg::REG_TILE_ROWS, tmocf_pkg::TILE_LIMIT);
                2:       write_reg(tmocf_pkg::REG_TILE_ROWS, 32'd127);
                default: write_reg(tmocf_pkg::REG_TILE_ROWS, $urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(tmocf_pkg::REG_TILE_COLUMNS, 32'd0);
                1:       write_reg(tmocf_pkg::REG_TILE_COLUMNS, tmocf_pkg::TILE_LIMIT);
                2:       write_reg(tmocf_pkg::REG_TILE_COLUMNS, 32'd127);
                default: write_reg(tmocf_pkg::REG_TILE_COLUMNS, $urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(tmocf_pkg::REG_ENABLE_MASK, 32'h0);
                1:       write_reg(tmocf_pkg::REG_ENABLE_MASK, 32'hFFFF_FFFF);
                default: write_reg(tmocf_pkg::REG_ENABLE_MASK, $urandom);
            endcase
            idling = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_CIRCLES; n++)
            begin
                if (phase == 3 && n == PHASE_CIRCLES / 2)
                    drain_outcomes();
                c = random_circle();
                send_circle(c, 1'b0, '0);
            end
        end

        // Closing stretch at full rate, no gaps on either side.
        idling = 1'b0;
        for (int n = 0; n < CLOSING_CIRCLES; n++)
        begin
            c = random_circle();
            send_circle(c, 1'b0, '0);
        end

        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_outcomes == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
